@@ hw/rtl/mmd_pkg.sv @@
// mmd_pkg: shared types, opcode patterns and helper functions for the mov byte decoder
package mmd_pkg;

	// opcode patterns and masks
	localparam logic [7:0] MaskRmReg = 8'b1111_1100;
	localparam logic [7:0] OpRmReg   = 8'b1000_1000;
	localparam logic [7:0] MaskIReg  = 8'b1111_0000;
	localparam logic [7:0] OpIReg    = 8'b1011_0000;
	localparam logic [7:0] MaskPair  = 8'b1111_1110;
	localparam logic [7:0] OpIRm     = 8'b1100_0110;
	localparam logic [7:0] OpMemAcc  = 8'b1010_0000;
	localparam logic [7:0] OpAccMem  = 8'b1010_0010;

	// mod field codes and the rm code that selects a direct address
	localparam logic [1:0] ModMem    = 2'd0;
	localparam logic [1:0] ModDisp8  = 2'd1;
	localparam logic [1:0] ModReg    = 2'd3;
	localparam logic [2:0] RmDirect  = 3'd6;

	typedef enum logic [2:0] {
		FORM_RM_REG  = 3'd0,
		FORM_IMM_RM  = 3'd1,
		FORM_IMM_REG = 3'd2,
		FORM_MEM_ACC = 3'd3,
		FORM_ACC_MEM = 3'd4,
		FORM_BAD     = 3'd5
	} mmd_form_t;

	typedef enum logic [2:0] {
		PH_OPCODE  = 3'd0,
		PH_MODRM   = 3'd1,
		PH_DISP_LO = 3'd2,
		PH_DISP_HI = 3'd3,
		PH_ADDR_LO = 3'd4,
		PH_ADDR_HI = 3'd5,
		PH_IMM_LO  = 3'd6,
		PH_IMM_HI  = 3'd7
	} mmd_phase_t;

	// decoded instruction record
	typedef struct packed {
		mmd_form_t          form;
		logic               wide;
		logic               to_reg;
		logic [1:0]         mode;
		logic [2:0]         reg_code;
		logic [2:0]         rm_code;
		logic               direct;
		logic signed [15:0] displacement;
		logic [15:0]        address;
		logic [15:0]        immediate;
		logic [2:0]         length;
		logic [7:0]         first_byte;
	} mmd_rec_t;

	// decoder status seen by the top level
	typedef struct packed {
		logic       emit;
		mmd_phase_t phase;
	} mmd_stat_t;

	function automatic mmd_form_t classify(input logic [7:0] op);
		mmd_form_t f;
		if ((op & MaskRmReg) == OpRmReg)     f = FORM_RM_REG;
		else if ((op & MaskPair) == OpIRm)    f = FORM_IMM_RM;
		else if ((op & MaskIReg) == OpIReg)   f = FORM_IMM_REG;
		else if ((op & MaskPair) == OpMemAcc) f = FORM_MEM_ACC;
		else if ((op & MaskPair) == OpAccMem) f = FORM_ACC_MEM;
		else                                  f = FORM_BAD;
		return f;
	endfunction

	function automatic logic op_wide(input logic [7:0] op);
		logic w;
		unique case (classify(op))
			FORM_IMM_REG: w = op[3];
			FORM_BAD:     w = 1'b0;
			default:      w = op[0];
		endcase
		return w;
	endfunction

endpackage

@@ hw/rtl/mmd_decode.sv @@
// mmd_decode: phase machine that gathers instruction bytes and builds the decoded record
module mmd_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic [7:0]        stream_byte,
	output mmd_pkg::mmd_rec_t rec,
	output mmd_pkg::mmd_stat_t stat
);

	mmd_pkg::mmd_phase_t phase_q, phase_nxt;
	logic [7:0]  opcode_q, opcode_nxt;
	logic [7:0]  modrm_q, modrm_nxt;
	logic [15:0] disp_q, disp_nxt;
	logic [15:0] addr_q, addr_nxt;
	logic [15:0] imm_q, imm_nxt;
	logic [2:0]  count_q, count_nxt;
	logic        fin;
	logic        emit;
	mmd_pkg::mmd_form_t form_nxt;

	// next state from the current byte
	always_comb begin
		phase_nxt  = phase_q;
		opcode_nxt = opcode_q;
		modrm_nxt  = modrm_q;
		disp_nxt   = disp_q;
		addr_nxt   = addr_q;
		imm_nxt    = imm_q;
		count_nxt  = count_q + 3'd1;
		fin        = 1'b0;
		emit       = 1'b0;
		unique case (phase_q)
			mmd_pkg::PH_OPCODE: begin
				opcode_nxt = stream_byte;
				modrm_nxt  = '0;
				disp_nxt   = '0;
				addr_nxt   = '0;
				imm_nxt    = '0;
				count_nxt  = 3'd1;
				unique case (mmd_pkg::classify(stream_byte)) inside
					mmd_pkg::FORM_RM_REG, mmd_pkg::FORM_IMM_RM:  phase_nxt = mmd_pkg::PH_MODRM;
					mmd_pkg::FORM_IMM_REG:                       phase_nxt = mmd_pkg::PH_IMM_LO;
					mmd_pkg::FORM_MEM_ACC, mmd_pkg::FORM_ACC_MEM: phase_nxt = mmd_pkg::PH_ADDR_LO;
					default:                                     emit = 1'b1;
				endcase
			end
			mmd_pkg::PH_MODRM: begin
				modrm_nxt = stream_byte;
				if (stream_byte[7:6] == mmd_pkg::ModReg) begin
					fin = 1'b1;
				end else if (stream_byte[7:6] == mmd_pkg::ModMem) begin
					if (stream_byte[2:0] == mmd_pkg::RmDirect) phase_nxt = mmd_pkg::PH_ADDR_LO;
					else fin = 1'b1;
				end else begin
					phase_nxt = mmd_pkg::PH_DISP_LO;
				end
			end
			mmd_pkg::PH_DISP_LO: begin
				if (modrm_q[7:6] == mmd_pkg::ModDisp8) begin
					disp_nxt = {{8{stream_byte[7]}}, stream_byte};
					fin      = 1'b1;
				end else begin
					disp_nxt  = {8'h00, stream_byte};
					phase_nxt = mmd_pkg::PH_DISP_HI;
				end
			end
			mmd_pkg::PH_DISP_HI: begin
				disp_nxt = {stream_byte, disp_q[7:0]};
				fin      = 1'b1;
			end
			mmd_pkg::PH_ADDR_LO: begin
				addr_nxt  = {8'h00, stream_byte};
				phase_nxt = mmd_pkg::PH_ADDR_HI;
			end
			mmd_pkg::PH_ADDR_HI: begin
				addr_nxt = {stream_byte, addr_q[7:0]};
				fin      = 1'b1;
			end
			mmd_pkg::PH_IMM_LO: begin
				imm_nxt = {8'h00, stream_byte};
				if (mmd_pkg::op_wide(opcode_q)) phase_nxt = mmd_pkg::PH_IMM_HI;
				else emit = 1'b1;
			end
			mmd_pkg::PH_IMM_HI: begin
				imm_nxt = {stream_byte, imm_q[7:0]};
				emit    = 1'b1;
			end
			default: ;
		endcase
		// addressing done: immediate to rm still needs its immediate
		if (fin) begin
			if (mmd_pkg::classify(opcode_q) == mmd_pkg::FORM_IMM_RM) begin
				phase_nxt = mmd_pkg::PH_IMM_LO;
			end else begin
				emit = 1'b1;
			end
		end
		if (emit) phase_nxt = mmd_pkg::PH_OPCODE;
	end

	// record built from the updated holds
	always_comb begin
		form_nxt         = mmd_pkg::classify(opcode_nxt);
		rec              = '0;
		rec.form         = form_nxt;
		rec.wide         = mmd_pkg::op_wide(opcode_nxt);
		rec.displacement = disp_nxt;
		rec.address      = addr_nxt;
		rec.immediate    = imm_nxt;
		rec.length       = count_nxt;
		rec.first_byte   = opcode_nxt;
		unique case (form_nxt) inside
			mmd_pkg::FORM_RM_REG, mmd_pkg::FORM_IMM_RM: begin
				rec.mode    = modrm_nxt[7:6];
				rec.rm_code = modrm_nxt[2:0];
				rec.direct  = (modrm_nxt[7:6] == mmd_pkg::ModMem) &&
					(modrm_nxt[2:0] == mmd_pkg::RmDirect);
				if (form_nxt == mmd_pkg::FORM_RM_REG) begin
					rec.to_reg   = opcode_nxt[1];
					rec.reg_code = modrm_nxt[5:3];
				end
			end
			mmd_pkg::FORM_IMM_REG: begin
				rec.to_reg   = 1'b1;
				rec.mode     = mmd_pkg::ModReg;
				rec.reg_code = opcode_nxt[2:0];
			end
			mmd_pkg::FORM_MEM_ACC: rec.to_reg = 1'b1;
			default: ;
		endcase
	end

	// phase and holds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= mmd_pkg::PH_OPCODE;
			opcode_q <= '0;
			modrm_q  <= '0;
			disp_q   <= '0;
			addr_q   <= '0;
			imm_q    <= '0;
			count_q  <= '0;
		end else if (advance) begin
			phase_q  <= phase_nxt;
			opcode_q <= opcode_nxt;
			modrm_q  <= modrm_nxt;
			disp_q   <= disp_nxt;
			addr_q   <= addr_nxt;
			imm_q    <= imm_nxt;
			count_q  <= count_nxt;
		end
	end

	assign stat.emit  = emit;
	assign stat.phase = phase_q;

endmodule

@@ hw/rtl/mmd_out_reg.sv @@
// mmd_out_reg: result register that holds a decoded record until it is taken
module mmd_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  mmd_pkg::mmd_rec_t rec,
	input  logic              out_ready,
	output logic              out_valid,
	output logic              free,
	output mmd_pkg::mmd_rec_t rec_q
);

	logic valid_q;

	// slot can take a record when empty or being drained this cycle
	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	// record payload
	always_ff @(posedge clk) begin
		if (free && load) begin
			rec_q <= rec;
		end
	end

endmodule

@@ hw/rtl/x86_16_mov_byte_stream_decoder.sv @@
// x86_16_mov_byte_stream_decoder: top level of the 16-bit mov byte stream decoder
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  input   | in_valid / in_ready  | stream_byte
//  output  | out_valid / out_ready| form wide to_reg mode reg_code rm_code
//          |                      | direct displacement address immediate
//          |                      | length first_byte
//
// one byte per cycle while the result slot is free: a request goes into the input
// register, then the phase machine folds it into the holds and, on the last byte
// of an instruction, loads the result register. reset clears the phase machine
// and both valid flags. a stalled result register holds the input register,
// and the input side keeps taking requests as long as the input register drains.
module x86_16_mov_byte_stream_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         stream_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         form,
	output logic               wide,
	output logic               to_reg,
	output logic [1:0]         mode,
	output logic [2:0]         reg_code,
	output logic [2:0]         rm_code,
	output logic               direct,
	output logic signed [15:0] displacement,
	output logic [15:0]        address,
	output logic [15:0]        immediate,
	output logic [2:0]         length,
	output logic [7:0]         first_byte
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              advance;
	logic              free;
	mmd_pkg::mmd_rec_t rec;
	mmd_pkg::mmd_rec_t rec_q;
	mmd_pkg::mmd_stat_t stat;

	// input register moves when the result slot is free
	assign advance  = valid_s1 && free;
	assign in_ready = !valid_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= stream_byte;
		end
	end

	mmd_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.stream_byte (byte_s1),
		.rec         (rec),
		.stat        (stat)
	);

	mmd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && stat.emit),
		.rec       (rec),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.free      (free),
		.rec_q     (rec_q)
	);

	// record fields to ports
	assign form         = rec_q.form;
	assign wide         = rec_q.wide;
	assign to_reg       = rec_q.to_reg;
	assign mode         = rec_q.mode;
	assign reg_code     = rec_q.reg_code;
	assign rm_code      = rec_q.rm_code;
	assign direct       = rec_q.direct;
	assign displacement = rec_q.displacement;
	assign address      = rec_q.address;
	assign immediate    = rec_q.immediate;
	assign length       = rec_q.length;
	assign first_byte   = rec_q.first_byte;

	// a finished instruction sends the phase machine back to the opcode
	a_emit_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance && stat.emit |=> stat.phase == mmd_pkg::PH_OPCODE)
		else $error("phase not back at opcode after a record");

	// an unsupported opcode is a one-byte record
	a_bad_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && form == mmd_pkg::FORM_BAD |-> length == 3'd1)
		else $error("unsupported opcode record with length other than one");

	// immediate to register always reports register mode and destination
	a_ireg_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && form == mmd_pkg::FORM_IMM_REG |-> mode == mmd_pkg::ModReg && to_reg)
		else $error("immediate to register record with wrong mode or direction");

	// a byte that does not finish an instruction never loads the result register
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !(advance && stat.emit) |=> !out_valid)
		else $error("record appeared without a finished instruction");

endmodule

@@ sim/tb_top.sv @@
// tb_top: self-checking testbench for the x86 16-bit mov byte stream decoder
`timescale 1ns / 100ps

module tb_top;

	localparam int unsigned CycleLimit = 500000;
	localparam int unsigned DrainCycles = 8;
	localparam int unsigned MaxReports = 10;
	localparam logic [1:0] ModDisp16 = 2'd2;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] stream_byte = 8'h00;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] form;
	logic wide;
	logic to_reg;
	logic [1:0] mode;
	logic [2:0] reg_code;
	logic [2:0] rm_code;
	logic direct;
	logic signed [15:0] displacement;
	logic [15:0] address;
	logic [15:0] immediate;
	logic [2:0] length;
	logic [7:0] first_byte;

	// decoder state mirrored by the testbench
	mmd_pkg::mmd_phase_t dec_phase = mmd_pkg::PH_OPCODE;
	logic [7:0] dec_op = 8'h00;
	logic [7:0] dec_modrm = 8'h00;
	logic [15:0] dec_disp = 16'h0000;
	logic [15:0] dec_addr = 16'h0000;
	logic [15:0] dec_imm = 16'h0000;
	logic [2:0] dec_count = 3'd0;

	mmd_pkg::mmd_rec_t decoded_q[$];
	mmd_pkg::mmd_rec_t exp_rec;
	mmd_pkg::mmd_rec_t got_rec;
	int unsigned err_count = 0;
	int unsigned bytes_taken = 0;
	int unsigned cycle_count = 0;
	int unsigned in_gap_max = 13;
	int unsigned out_gap_max = 13;

	x86_16_mov_byte_stream_decoder u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stream_byte(stream_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.form(form),
		.wide(wide),
		.to_reg(to_reg),
		.mode(mode),
		.reg_code(reg_code),
		.rm_code(rm_code),
		.direct(direct),
		.displacement(displacement),
		.address(address),
		.immediate(immediate),
		.length(length),
		.first_byte(first_byte)
	);

	always #5 clk = ~clk;

	// opcode class of a byte
	function automatic mmd_pkg::mmd_form_t kind_of(input logic [7:0] op);
		if ((op & mmd_pkg::MaskRmReg) == mmd_pkg::OpRmReg) return mmd_pkg::FORM_RM_REG;
		if ((op & mmd_pkg::MaskPair) == mmd_pkg::OpIRm) return mmd_pkg::FORM_IMM_RM;
		if ((op & mmd_pkg::MaskIReg) == mmd_pkg::OpIReg) return mmd_pkg::FORM_IMM_REG;
		if ((op & mmd_pkg::MaskPair) == mmd_pkg::OpMemAcc) return mmd_pkg::FORM_MEM_ACC;
		if ((op & mmd_pkg::MaskPair) == mmd_pkg::OpAccMem) return mmd_pkg::FORM_ACC_MEM;
		return mmd_pkg::FORM_BAD;
	endfunction

	// word operand size; short immediate form keeps it in bit 3
	function automatic logic is_word(input logic [7:0] op);
		case (kind_of(op))
			mmd_pkg::FORM_IMM_REG: return op[3];
			mmd_pkg::FORM_BAD: return 1'b0;
			default: return op[0];
		endcase
	endfunction

	function automatic string rec_text(input mmd_pkg::mmd_rec_t r);
		return $sformatf({"form %0d w %0d d %0d mod %0d reg %0d rm %0d dir %0d",
			" disp %04h addr %04h imm %04h len %0d op %02h"},
			r.form, r.wide, r.to_reg, r.mode, r.reg_code, r.rm_code, r.direct,
			r.displacement, r.address, r.immediate, r.length, r.first_byte);
	endfunction

	// record of the finished instruction, unused fields held at zero
	task automatic push_record();
		mmd_pkg::mmd_rec_t r;
		mmd_pkg::mmd_form_t f;
		f = kind_of(dec_op);
		r = '0;
		r.form = f;
		r.wide = is_word(dec_op);
		r.displacement = dec_disp;
		r.address = dec_addr;
		r.immediate = dec_imm;
		r.length = dec_count;
		r.first_byte = dec_op;
		case (f)
			mmd_pkg::FORM_RM_REG, mmd_pkg::FORM_IMM_RM: begin
				r.mode = dec_modrm[7:6];
				r.rm_code = dec_modrm[2:0];
				r.direct = (dec_modrm[7:6] == mmd_pkg::ModMem) &&
					(dec_modrm[2:0] == mmd_pkg::RmDirect);
				if (f == mmd_pkg::FORM_RM_REG) begin
					r.to_reg = dec_op[1];
					r.reg_code = dec_modrm[5:3];
				end
			end
			mmd_pkg::FORM_IMM_REG: begin
				r.to_reg = 1'b1;
				r.mode = mmd_pkg::ModReg;
				r.reg_code = dec_op[2:0];
			end
			mmd_pkg::FORM_MEM_ACC: r.to_reg = 1'b1;
			default: ;
		endcase
		decoded_q.push_back(r);
		dec_phase = mmd_pkg::PH_OPCODE;
	endtask

	// addressing complete: immediate to rm still needs its data
	task automatic operand_done();
		if (kind_of(dec_op) == mmd_pkg::FORM_IMM_RM) dec_phase = mmd_pkg::PH_IMM_LO;
		else push_record();
	endtask

	// fold one accepted byte into the mirrored decoder state
	task automatic decode_byte(input logic [7:0] b);
		if (dec_phase == mmd_pkg::PH_OPCODE) begin
			dec_op = b;
			dec_modrm = 8'h00;
			dec_disp = 16'h0000;
			dec_addr = 16'h0000;
			dec_imm = 16'h0000;
			dec_count = 3'd1;
			case (kind_of(b))
				mmd_pkg::FORM_RM_REG, mmd_pkg::FORM_IMM_RM: dec_phase = mmd_pkg::PH_MODRM;
				mmd_pkg::FORM_IMM_REG: dec_phase = mmd_pkg::PH_IMM_LO;
				mmd_pkg::FORM_MEM_ACC, mmd_pkg::FORM_ACC_MEM: dec_phase = mmd_pkg::PH_ADDR_LO;
				default: push_record();
			endcase
		end else begin
			dec_count = dec_count + 3'd1;
			case (dec_phase)
				mmd_pkg::PH_MODRM: begin
					dec_modrm = b;
					if (b[7:6] == mmd_pkg::ModReg) operand_done();
					else if (b[7:6] == mmd_pkg::ModMem) begin
						if (b[2:0] == mmd_pkg::RmDirect) dec_phase = mmd_pkg::PH_ADDR_LO;
						else operand_done();
					end else dec_phase = mmd_pkg::PH_DISP_LO;
				end
				mmd_pkg::PH_DISP_LO: begin
					if (dec_modrm[7:6] == mmd_pkg::ModDisp8) begin
						dec_disp = {{8{b[7]}}, b};
						operand_done();
					end else begin
						dec_disp = {8'h00, b};
						dec_phase = mmd_pkg::PH_DISP_HI;
					end
				end
				mmd_pkg::PH_DISP_HI: begin
					dec_disp[15:8] = b;
					operand_done();
				end
				mmd_pkg::PH_ADDR_LO: begin
					dec_addr = {8'h00, b};
					dec_phase = mmd_pkg::PH_ADDR_HI;
				end
				mmd_pkg::PH_ADDR_HI: begin
					dec_addr[15:8] = b;
					operand_done();
				end
				mmd_pkg::PH_IMM_LO: begin
					dec_imm = {8'h00, b};
					if (is_word(dec_op)) dec_phase = mmd_pkg::PH_IMM_HI;
					else push_record();
				end
				default: begin
					dec_imm[15:8] = b;
					push_record();
				end
			endcase
		end
	endtask

	// one request on the input channel; valid stays high for a back-to-back byte
	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		gap = $urandom_range(0, in_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		stream_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		decode_byte(b);
		bytes_taken++;
	endtask

	// random byte with extra weight on the extremes
	function automatic logic [7:0] rnd_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			2: return ($urandom_range(0, 1) != 0) ? 8'h7F : 8'h80;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// displacement or direct address bytes that the mod-reg-rm byte calls for
	task automatic send_addressing(input logic [7:0] modrm);
		if (modrm[7:6] == mmd_pkg::ModDisp8) send_byte(rnd_byte());
		else if (modrm[7:6] == ModDisp16 ||
				(modrm[7:6] == mmd_pkg::ModMem && modrm[2:0] == mmd_pkg::RmDirect)) begin
			send_byte(rnd_byte());
			send_byte(rnd_byte());
		end
	endtask

	// one well-formed instruction of a random form with random content
	task automatic send_instr();
		logic [7:0] op;
		logic [7:0] modrm;
		op = 8'($urandom_range(0, 255));
		modrm = rnd_byte();
		case ($urandom_range(0, 5))
			0: begin
				op = mmd_pkg::OpRmReg | (op & ~mmd_pkg::MaskRmReg);
				send_byte(op);
				send_byte(modrm);
				send_addressing(modrm);
			end
			1: begin
				op = mmd_pkg::OpIRm | (op & ~mmd_pkg::MaskPair);
				send_byte(op);
				send_byte(modrm);
				send_addressing(modrm);
				send_byte(rnd_byte());
				if (op[0]) send_byte(rnd_byte());
			end
			2: begin
				op = mmd_pkg::OpIReg | (op & ~mmd_pkg::MaskIReg);
				send_byte(op);
				send_byte(rnd_byte());
				if (op[3]) send_byte(rnd_byte());
			end
			3, 4: begin
				op = (($urandom_range(0, 1) != 0) ? mmd_pkg::OpMemAcc : mmd_pkg::OpAccMem) |
					(op & ~mmd_pkg::MaskPair);
				send_byte(op);
				send_byte(rnd_byte());
				send_byte(rnd_byte());
			end
			default: begin
				while (kind_of(op) != mmd_pkg::FORM_BAD) op = 8'($urandom_range(0, 255));
				send_byte(op);
			end
		endcase
	endtask

	// register/memory forms over the memory, disp8 and disp16 mod values and both directions
	task automatic test_rm_reg();
		send_byte(8'h88);
		send_byte(8'h07);
		send_byte(8'h8B);
		send_byte(8'h46);
		send_byte(8'h80);
		send_byte(8'h89);
		send_byte(8'h96);
		send_byte(8'h34);
		send_byte(8'h12);
	endtask

	// immediate forms; reg field of the immediate-to-rm byte is ignored
	task automatic test_immediate();
		send_byte(8'hC6);
		send_byte(8'hF8);
		send_byte(8'h80);
		send_byte(8'hC7);
		send_byte(8'h3E);
		send_byte(8'h00);
		send_byte(8'h80);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hB0);
		send_byte(8'h7F);
		send_byte(8'hBF);
		send_byte(8'hFF);
		send_byte(8'hFF);
	endtask

	// accumulator forms always take a two-byte address
	task automatic test_accumulator();
		send_byte(8'hA1);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'hA2);
		send_byte(8'hFF);
		send_byte(8'hFF);
	endtask

	// unsupported opcodes give a record at once and decoding restarts
	task automatic test_unsupported();
		send_byte(8'hFF);
		send_byte(8'h00);
	endtask

	task automatic test_random_stream(input int unsigned n);
		int unsigned start;
		start = bytes_taken;
		in_gap_max = 13;
		out_gap_max = 13;
		while (bytes_taken - start < n) send_instr();
	endtask

	// no idling on either side
	task automatic test_back_to_back(input int unsigned n);
		int unsigned start;
		start = bytes_taken;
		in_gap_max = 0;
		out_gap_max = 0;
		while (bytes_taken - start < n) send_instr();
	endtask

	// fast source into a stalling sink
	task automatic test_slow_sink(input int unsigned n);
		int unsigned start;
		start = bytes_taken;
		in_gap_max = 0;
		out_gap_max = 13;
		while (bytes_taken - start < n) send_instr();
	endtask

	// raw random bytes mixed with well-formed instructions
	task automatic test_noise(input int unsigned n);
		int unsigned start;
		start = bytes_taken;
		in_gap_max = 13;
		out_gap_max = 0;
		while (bytes_taken - start < n) begin
			if ($urandom_range(0, 1) != 0) send_byte(8'($urandom_range(0, 255)));
			else send_instr();
		end
	endtask

	// result side: random stall before each record
	initial begin : sink
		int unsigned gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = $urandom_range(0, out_gap_max);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// compare each accepted record with the oldest decoded one
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got_rec.form = mmd_pkg::mmd_form_t'(form);
			got_rec.wide = wide;
			got_rec.to_reg = to_reg;
			got_rec.mode = mode;
			got_rec.reg_code = reg_code;
			got_rec.rm_code = rm_code;
			got_rec.direct = direct;
			got_rec.displacement = displacement;
			got_rec.address = address;
			got_rec.immediate = immediate;
			got_rec.length = length;
			got_rec.first_byte = first_byte;
			if (decoded_q.size() == 0) begin
				if (err_count < MaxReports)
					$display("%0t: record with none pending: %s", $time, rec_text(got_rec));
				err_count++;
			end else begin
				exp_rec = decoded_q.pop_front();
				if (got_rec.form !== exp_rec.form || got_rec.wide !== exp_rec.wide ||
						got_rec.to_reg !== exp_rec.to_reg || got_rec.mode !== exp_rec.mode ||
						got_rec.reg_code !== exp_rec.reg_code ||
						got_rec.rm_code !== exp_rec.rm_code ||
						got_rec.direct !== exp_rec.direct ||
						got_rec.displacement !== exp_rec.displacement ||
						got_rec.address !== exp_rec.address ||
						got_rec.immediate !== exp_rec.immediate ||
						got_rec.length !== exp_rec.length ||
						got_rec.first_byte !== exp_rec.first_byte) begin
					if (err_count < MaxReports) begin
						$display("%0t: record mismatch", $time);
						$display("  expected %s", rec_text(exp_rec));
						$display("  actual   %s", rec_text(got_rec));
					end
					err_count++;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CycleLimit) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_rm_reg();
		test_immediate();
		test_accumulator();
		test_unsupported();
		test_random_stream(700);
		test_back_to_back(400);
		test_slow_sink(400);
		test_noise(300);
		in_valid <= 1'b0;
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (err_count == 0) $display("tb_top: PASS");
		else $display("tb_top: FAIL");
		$finish;
	end

endmodule
